// ----- rtl/rfs_pkg.sv -----
package rfs_pkg;

   localparam int DATA_W   = 16;
   localparam int CUR_W    = 9;
   localparam int COUNT_W  = 6;
   localparam int FRAME_W  = 7;
   localparam int STATUS_W = 2;

   localparam logic [DATA_W-1:0] FRAME_MARKER = 16'h4FFF;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROP = 2'd2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SEND = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic drop;
      logic start;
      logic fetch;
      logic emit;
      logic commit;
      logic clear;
   } rfs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_capacity;
      logic collide;
      logic final_word;
      logic out_free;
   } rfs_stat_type;

endpackage

// ----- rtl/rfs_ram.sv -----
module rfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 60,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rfs_datapath.sv -----
module rfs_datapath
   import rfs_pkg::*;
#(
   parameter int MAX_WORDS  = 60,
   parameter int RING_DEPTH = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  rfs_cmd_type         cmd,
   output rfs_stat_type        stat,
   input  logic [DATA_W-1:0]   data_word,
   input  logic [CUR_W-1:0]    read_cursor,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [CUR_W-1:0]    rsp_ring_index,
   output logic [DATA_W-1:0]   rsp_ring_data,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_sent_count
);

   localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic [CUR_W-1:0]    write_cursor_ff, write_cursor_in;
   logic [COUNT_W-1:0]  loaded_count_ff, loaded_count_in;
   logic [DATA_W-1:0]   weighted_sum_ff, weighted_sum_in;
   logic [DATA_W-1:0]   complement_sum_ff, complement_sum_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [CUR_W-1:0]    rd_ff, rd_in;
   logic [FRAME_W-1:0]  k_ff, k_in;
   logic                out_valid_ff, out_valid_in;
   logic [CUR_W-1:0]    out_index_ff, out_index_in;
   logic [DATA_W-1:0]   out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic [FRAME_W-1:0]          position;
   logic [DATA_W+FRAME_W-1:0]   product_full;
   logic [DATA_W-1:0]           product;
   logic [CUR_W-1:0]            cur_next;
   logic [FRAME_W-1:0]          payload_k;
   logic [ADDR_W-1:0]           rd_addr;
   logic [DATA_W-1:0]           ram_rd_data;
   logic [DATA_W-1:0]           frame_word;
   logic                        out_free;

   assign position     = FRAME_W'(loaded_count_ff) + FRAME_W'(1);
   assign product_full = (DATA_W+FRAME_W)'(data_word) * (DATA_W+FRAME_W)'(position);
   assign product      = product_full[DATA_W-1:0];

   assign cur_next  = (cur_ff == CUR_W'(RING_DEPTH - 1)) ? '0 : cur_ff + CUR_W'(1);
   assign payload_k = k_ff - FRAME_W'(4);
   assign rd_addr   = (k_ff >= FRAME_W'(4)) ? payload_k[ADDR_W-1:0] : '0;
   assign out_free  = !out_valid_ff || rsp_ready;

   rfs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (loaded_count_ff[ADDR_W-1:0]),
      .wr_data (data_word),
      .rd_en   (cmd.fetch),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (k_ff)
         FRAME_W'(0): frame_word = FRAME_MARKER;
         FRAME_W'(1): frame_word = DATA_W'(loaded_count_ff);
         FRAME_W'(2): frame_word = weighted_sum_ff + DATA_W'(loaded_count_ff) + FRAME_MARKER;
         FRAME_W'(3): frame_word = complement_sum_ff;
         default:     frame_word = ram_rd_data;
      endcase
   end

   assign stat.at_capacity = loaded_count_ff >= COUNT_W'(MAX_WORDS);
   assign stat.collide     = cur_next == rd_ff;
   assign stat.final_word  = k_ff == FRAME_W'(loaded_count_ff) + FRAME_W'(3);
   assign stat.out_free    = out_free;

   always_comb begin
      write_cursor_in   = write_cursor_ff;
      loaded_count_in   = loaded_count_ff;
      weighted_sum_in   = weighted_sum_ff;
      complement_sum_in = complement_sum_ff;
      cur_in            = cur_ff;
      rd_in             = rd_ff;
      k_in              = k_ff;
      out_valid_in      = out_valid_ff && !rsp_ready;
      out_index_in      = out_index_ff;
      out_data_in       = out_data_ff;
      out_last_in       = out_last_ff;
      out_status_in     = out_status_ff;
      out_count_in      = out_count_ff;

      if (cmd.load) begin
         loaded_count_in   = loaded_count_ff + COUNT_W'(1);
         weighted_sum_in   = weighted_sum_ff + product;
         complement_sum_in = complement_sum_ff + ~product;
      end
      if (cmd.drop) begin
         out_valid_in  = 1'b1;
         out_index_in  = '0;
         out_data_in   = '0;
         out_last_in   = 1'b1;
         out_status_in = STATUS_DROP;
         out_count_in  = '0;
      end
      if (cmd.start) begin
         cur_in = write_cursor_ff;
         rd_in  = read_cursor;
         k_in   = '0;
      end
      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_index_in  = cur_ff;
         out_data_in   = frame_word;
         out_last_in   = stat.collide || stat.final_word;
         out_status_in = stat.collide ? STATUS_FULL : STATUS_OK;
         out_count_in  = (!stat.collide && stat.final_word) ? loaded_count_ff : '0;
         cur_in        = cur_next;
         k_in          = k_ff + FRAME_W'(1);
      end
      if (cmd.commit) begin
         write_cursor_in = cur_next;
      end
      if (cmd.clear) begin
         loaded_count_in   = '0;
         weighted_sum_in   = '0;
         complement_sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_cursor_ff   <= '0;
         loaded_count_ff   <= '0;
         weighted_sum_ff   <= '0;
         complement_sum_ff <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         write_cursor_ff   <= write_cursor_in;
         loaded_count_ff   <= loaded_count_in;
         weighted_sum_ff   <= weighted_sum_in;
         complement_sum_ff <= complement_sum_in;
         out_valid_ff      <= out_valid_in;
      end
      cur_ff        <= cur_in;
      rd_ff         <= rd_in;
      k_ff          <= k_in;
      out_index_ff  <= out_index_in;
      out_data_ff   <= out_data_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ring_index = out_index_ff;
   assign rsp_ring_data  = out_data_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_sent_count = out_count_ff;

endmodule

// ----- rtl/rfs_ctrl.sv -----
module rfs_ctrl
   import rfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_opcode,
   output logic         req_ready,
   input  rfs_stat_type stat,
   output rfs_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FETCH = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_SEND) begin
                  cmd.start = 1'b1;
                  state_in  = S_FETCH;
               end else if (stat.at_capacity) begin
                  cmd.drop = 1'b1;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_FETCH: begin
            // store read for this frame slot, data lands next cycle
            cmd.fetch = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.collide) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end else if (stat.final_word) begin
                  cmd.commit = 1'b1;
                  cmd.clear  = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ring_frame_sender_weighted_sum.sv -----
// Ring frame sender with weighted checksum.
// req channel: one transaction is a load (tuser 0) that stages tdata's payload
// word, or a send (tuser 1) that writes the staged frame into the ring, with
// tdata carrying the consumer's read cursor.
// rsp channel: one transaction per ring write or dropped load: slot index, halfword,
// sent count, with status in tuser and tlast on the final write of a send or a drop.
// A frame is marker, count, checksum, complement sum, then the payload words.
// Loads return nothing, so they stream at one per cycle while the output register is free.
// A load at capacity returns a single drop transaction in the next cycle.
// A send makes 4+n ring writes for n staged words:
// each write is a registered read of the payload store followed by a load of
// the output register.
// A ring collision ends the send early with a full status; the write cursor
// keeps its old value. Staging is cleared after every send.
// When rsp is stalled the output register holds and the sequencer waits;
// req_tready stays low during a send.
// Reset clears the write cursor, staging count, sums and the output valid flag;
// the payload store needs no clearing.
module ring_frame_sender_weighted_sum
   import rfs_pkg::*;
#(
   parameter int MAX_WORDS  = 60,
   parameter int RING_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // data_word[15:0], read_cursor[24:16], zero pad
   input  logic        req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // ring_index[8:0], ring_data[24:9], sent_count[30:25]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser   // status
);

   rfs_cmd_type         cmd;
   rfs_stat_type        stat;
   logic [CUR_W-1:0]    ring_index;
   logic [DATA_W-1:0]   ring_data;
   logic [COUNT_W-1:0]  sent_count;
   logic [STATUS_W-1:0] status;

   rfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_tuser),
      .req_ready  (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rfs_datapath #(
      .MAX_WORDS  (MAX_WORDS),
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .data_word      (req_tdata[15:0]),
      .read_cursor    (req_tdata[24:16]),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_ring_index (ring_index),
      .rsp_ring_data  (ring_data),
      .rsp_last       (rsp_tlast),
      .rsp_status     (status),
      .rsp_sent_count (sent_count)
   );

   assign rsp_tdata = {1'b0, sent_count, ring_data, ring_index};
   assign rsp_tuser = status;

endmodule

// ----- tb/tb_ring_frame_sender_weighted_sum.sv -----
`timescale 1ns / 100ps

module tb_ring_frame_sender_weighted_sum;
   import rfs_pkg::*;

   localparam int STAGE_DEPTH = 60;
   localparam int RANDOM_ITEMS = 370;

   typedef struct packed {
      logic [8:0]  slot;
      logic [15:0] half;
      logic        fin;
      logic [1:0]  stat;
      logic [5:0]  count;
   } ring_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // data_word[15:0], read_cursor[24:16], zero pad
   logic        req_tuser = OP_LOAD;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;  // ring_index[8:0], ring_data[24:9], sent_count[30:25]
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;  // status

   // predictor state
   logic [8:0]  model_cursor = '0;
   logic [15:0] staged_words [STAGE_DEPTH];
   int          staged_count = 0;
   logic [15:0] weighted_acc = '0;
   logic [15:0] complement_acc = '0;

   ring_write_type pending_writes [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   bit          req_quiet = 1'b0;
   bit          rsp_quiet = 1'b0;
   int unsigned rsp_hold = 0;

   ring_frame_sender_weighted_sum i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void push_write(logic [8:0] slot, logic [15:0] half, logic fin,
                                      logic [1:0] stat, logic [5:0] count);
      ring_write_type w;
      w = '{slot: slot, half: half, fin: fin, stat: stat, count: count};
      pending_writes.push_back(w);
   endfunction

   function automatic void clear_staging();
      staged_count = 0;
      weighted_acc = '0;
      complement_acc = '0;
   endfunction

   // expected ring writes for one accepted transaction
   function automatic void predict_ring_writes(logic op, logic [15:0] word, logic [8:0] rd);
      logic [15:0] frame [64];
      logic [15:0] pos;
      logic [15:0] prod;
      logic [8:0]  cur;
      logic [8:0]  slot;
      int          total;
      if (op == OP_LOAD) begin
         if (staged_count >= STAGE_DEPTH) begin
            push_write('0, '0, 1'b1, STATUS_DROP, '0);
            return;
         end
         staged_words[staged_count] = word;
         pos = 16'(staged_count + 1);
         prod = word * pos;
         weighted_acc = weighted_acc + prod;
         complement_acc = complement_acc + ~prod;
         staged_count++;
         return;
      end
      frame[0] = FRAME_MARKER;
      frame[1] = 16'(staged_count);
      frame[2] = weighted_acc + 16'(staged_count) + FRAME_MARKER;
      frame[3] = complement_acc;
      for (int k = 0; k < staged_count; k++)
         frame[4 + k] = staged_words[k];
      total = 4 + staged_count;
      cur = model_cursor;
      for (int k = 0; k < total; k++) begin
         slot = cur;
         cur = cur + 9'd1;
         if (cur == rd) begin
            push_write(slot, frame[k], 1'b1, STATUS_FULL, '0);
            clear_staging();
            return;
         end
         if (k == total - 1)
            push_write(slot, frame[k], 1'b1, STATUS_OK, 6'(staged_count));
         else
            push_write(slot, frame[k], 1'b0, STATUS_OK, '0);
      end
      model_cursor = cur;
      clear_staging();
   endfunction

   // one transaction on req; valid stays up across back-to-back items
   task automatic send_item(logic op, logic [15:0] word, logic [8:0] rd);
      int unsigned gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, rd, word};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ring_writes(op, word, rd);
      items_sent++;
   endtask

   task automatic load_words(int count);
      for (int i = 0; i < count; i++)
         send_item(OP_LOAD, 16'($urandom), 9'($urandom));
   endtask

   // a read cursor that no write of the coming frame reaches
   function automatic logic [8:0] clear_cursor();
      int total;
      total = 4 + staged_count;
      return model_cursor + 9'(total + 1 + $urandom_range(0, 510 - total));
   endfunction

   task automatic test_empty_send();
      send_item(OP_SEND, 16'hFFFF, clear_cursor());
      send_item(OP_SEND, 16'h0000, clear_cursor());
   endtask

   task automatic test_word_extremes();
      send_item(OP_LOAD, 16'hFFFF, 9'h1FF);
      send_item(OP_LOAD, 16'h0000, 9'h000);
      send_item(OP_LOAD, 16'h8000, 9'h155);
      send_item(OP_LOAD, 16'h0001, 9'h0AA);
      send_item(OP_LOAD, 16'hFFFF, 9'h1FF);
      send_item(OP_SEND, 16'h0000, clear_cursor());
   endtask

   task automatic test_ring_full();
      // collision on the marker write
      send_item(OP_SEND, 16'h0000, model_cursor + 9'd1);
      // collision on the first payload word
      load_words(2);
      send_item(OP_SEND, 16'h1234, model_cursor + 9'd5);
      // collision on the final write of the frame
      load_words(1);
      send_item(OP_SEND, 16'h0000, model_cursor + 9'd5);
      // read cursor at the write cursor itself is never reached
      load_words(1);
      send_item(OP_SEND, 16'hFFFF, model_cursor);
   endtask

   task automatic test_capacity();
      req_quiet = 1'b1;
      load_words(STAGE_DEPTH);
      req_quiet = 1'b0;
      load_words(2);
      send_item(OP_SEND, 16'($urandom), clear_cursor());
   endtask

   task automatic test_random_frames();
      int start;
      int len;
      int pick;
      int total;
      logic [8:0] rd;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         req_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 2) begin
            // noise: arbitrary mix of loads and sends
            repeat ($urandom_range(1, 5))
               send_item(1'($urandom), 16'($urandom), 9'($urandom));
            continue;
         end
         if (pick < 4)
            len = $urandom_range(9, STAGE_DEPTH);
         else if (pick == 4)
            len = $urandom_range(STAGE_DEPTH + 1, STAGE_DEPTH + 3);
         else
            len = $urandom_range(0, 8);
         load_words(len);
         total = 4 + staged_count;
         pick = $urandom_range(0, 9);
         if (pick < 7)
            rd = clear_cursor();
         else if (pick < 9)
            rd = model_cursor + 9'($urandom_range(1, total));
         else
            rd = 9'($urandom);
         send_item(OP_SEND, 16'($urandom), rd);
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   always @(posedge clock) begin : rsp_pacing
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         pause = rsp_quiet ? 0 : $urandom_range(0, 19);
         rsp_tready <= (pause == 0);
         rsp_hold <= pause;
      end else if (!rsp_tready) begin
         if (rsp_hold <= 1) rsp_tready <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end
   end

   function automatic void compare_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      ring_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual idx=%0h data=%0h",
                     $time, rsp_tdata[8:0], rsp_tdata[24:9]);
            mismatch_count++;
         end else begin
            want = pending_writes.pop_front();
            compare_field("ring_index", want.slot, rsp_tdata[8:0]);
            compare_field("ring_data", want.half, rsp_tdata[24:9]);
            compare_field("sent_count", want.count, rsp_tdata[30:25]);
            compare_field("last", want.fin, rsp_tlast);
            compare_field("status", want.stat, rsp_tuser);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_send();
      test_word_extremes();
      test_ring_full();
      test_capacity();
      test_random_frames();
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
